[design/cmof_pkg.sv]
`default_nettype none
package cmof_pkg;

	localparam int DATA_W = 16;
	localparam logic [DATA_W-1:0] THR_RESET = 16'd768;

	// controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_I,
		S_CAP_I,
		S_SCAN,
		S_DRAIN,
		S_TEST,
		S_M1,
		S_M2,
		S_M3,
		S_M4,
		S_M5,
		S_M6,
		S_M7,
		S_OUT
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic store;
		logic cap;
		logic scan;
		logic next_i;
		logic take_med;
		logic m1;
		logic m2;
		logic m3;
		logic m4;
		logic m5;
		logic m6;
		logic m7;
		logic load_out;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic scan_last;
		logic found;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

[design/conditional_median_outlier_filter_top.sv]
`default_nettype none
// Sigma-conditioned median filter.
// Input stream s_axis: one window sample per transfer; tuser marks the centre
// sample and tlast closes the window. Output stream m_axis: one result per
// closed window, the median or the centre, with tuser set when replaced.
// cfg_wr_en/cfg_wr_data write the Q8.8 threshold multiplier (reset 3.0);
// write it only while the block is idle.
// Throughput: samples are taken one per cycle while a window fills. On the
// closing transfer the block stops taking input and ranks the stored
// window: each candidate is read and compared with every stored sample
// (one memory read per compare), at most n candidates (n = count), then
// the exact squared deviation test runs through steps M1 to M7.
// Samples past WINDOW_SIZE in one window are dropped.
// The result waits in an output register; the next window may fill while
// it is not taken, and a new result waits until the old one is taken.
// Reset clears the window count, sums, centre and output valid, and sets the
// threshold to 3.0. Window store contents are not cleared.
module conditional_median_outlier_filter_top #(
	parameter int WINDOW_SIZE = 27
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_wr_en,
	input  wire  [15:0] cfg_wr_data,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [15:0] s_axis_tdata,   // [15:0] sample
	input  wire         s_axis_tuser,   // [0] is_center
	input  wire         s_axis_tlast,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] filtered_value
	output logic        m_axis_tuser    // [0] replaced
);

	cmof_pkg::cmd_t    cmd;
	cmof_pkg::status_t status;
	logic signed [15:0] out_value;

	cmof_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	cmof_dp #(.WINDOW_SIZE(WINDOW_SIZE)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_sample    (s_axis_tdata),
		.in_center    (s_axis_tuser),
		.cmd          (cmd),
		.status       (status),
		.out_value    (out_value),
		.out_replaced (m_axis_tuser),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready)
	);

	assign m_axis_tdata = out_value;

	// closing transfer stops intake for the ranking pass
	a_close_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input taken right after window close");

	// a new result only follows the ranking and test phase
	a_out_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result appeared without a ranking phase");

	// a result load never happens while intake is open
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !s_axis_tready)
		else $error("result loaded while accepting input");

endmodule
`default_nettype wire

[design/cmof_ctrl.sv]
`default_nettype none
module cmof_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	input  wire                in_last,
	output logic               in_ready,
	input  cmof_pkg::status_t  status,
	output cmof_pkg::cmd_t     cmd
);

	cmof_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cmof_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			cmof_pkg::S_IDLE: begin
				in_ready  = 1'b1;
				cmd.store = in_valid;
				if (in_valid && in_last) state_d = cmof_pkg::S_RD_I;
			end
			cmof_pkg::S_RD_I:  state_d = cmof_pkg::S_CAP_I;
			cmof_pkg::S_CAP_I: begin
				cmd.cap = 1'b1;
				state_d = cmof_pkg::S_SCAN;
			end
			cmof_pkg::S_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_last) state_d = cmof_pkg::S_DRAIN;
			end
			cmof_pkg::S_DRAIN: state_d = cmof_pkg::S_TEST;
			cmof_pkg::S_TEST: begin
				if (status.found) begin
					cmd.take_med = 1'b1;
					state_d      = cmof_pkg::S_M1;
				end else begin
					cmd.next_i = 1'b1;
					state_d    = cmof_pkg::S_RD_I;
				end
			end
			cmof_pkg::S_M1: begin cmd.m1 = 1'b1; state_d = cmof_pkg::S_M2; end
			cmof_pkg::S_M2: begin cmd.m2 = 1'b1; state_d = cmof_pkg::S_M3; end
			cmof_pkg::S_M3: begin cmd.m3 = 1'b1; state_d = cmof_pkg::S_M4; end
			cmof_pkg::S_M4: begin cmd.m4 = 1'b1; state_d = cmof_pkg::S_M5; end
			cmof_pkg::S_M5: begin cmd.m5 = 1'b1; state_d = cmof_pkg::S_M6; end
			cmof_pkg::S_M6: begin cmd.m6 = 1'b1; state_d = cmof_pkg::S_M7; end
			cmof_pkg::S_M7: begin cmd.m7 = 1'b1; state_d = cmof_pkg::S_OUT; end
			cmof_pkg::S_OUT: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = cmof_pkg::S_IDLE;
				end
			end
			default: state_d = cmof_pkg::S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

[design/cmof_dp.sv]
`default_nettype none
module cmof_dp #(
	parameter int WINDOW_SIZE = 27
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_wr_en,
	input  wire  [cmof_pkg::DATA_W-1:0]         cfg_wr_data,
	input  wire  signed [cmof_pkg::DATA_W-1:0]  in_sample,
	input  wire                                 in_center,
	input  cmof_pkg::cmd_t                      cmd,
	output cmof_pkg::status_t                   status,
	output logic signed [cmof_pkg::DATA_W-1:0]  out_value,
	output logic                                out_replaced,
	output logic                                out_valid,
	input  wire                                 out_ready
);

	localparam int DW      = cmof_pkg::DATA_W;
	localparam int CNT_W   = $clog2(WINDOW_SIZE + 1);
	localparam int AW      = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam int SUM_W   = DW + CNT_W;
	localparam int SQ_W    = 2 * DW - 1 + CNT_W;
	localparam int ND_W    = DW + CNT_W;
	localparam int VW      = CNT_W + SQ_W;
	localparam int VL      = VW / 2;
	localparam int VH      = VW - VL;
	localparam int TT_W    = 2 * DW;
	localparam int RIGHT_W = TT_W + VW;

	logic signed [DW-1:0] mem [WINDOW_SIZE];
	logic signed [DW-1:0] rd_q, cand_q, med_q, centre_q;
	logic [DW-1:0]        thr_q;
	logic [CNT_W-1:0]     cnt_q, i_q, j_q, less_q, leq_q, k;
	logic signed [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]      sq_q;
	logic                 scan_v_q;
	logic [VW-1:0]        ns2_q, ss_q, v_q;
	logic [ND_W-1:0]      nd_q;
	logic [TT_W-1:0]      tt_q;
	logic [2*ND_W-1:0]    left_q;
	logic [TT_W+VL-1:0]   rlo_q;
	logic [TT_W+VH-1:0]   rhi_q;
	logic [RIGHT_W-1:0]   right_q;
	logic                 rep_q;
	logic [SUM_W-1:0]     abs_sum;
	logic signed [DW:0]   diff;
	logic [DW-1:0]        absd;
	logic [AW-1:0]        rd_addr;
	logic                 room;

	assign room    = cnt_q < CNT_W'(WINDOW_SIZE);
	assign rd_addr = cmd.scan ? j_q[AW-1:0] : i_q[AW-1:0];
	assign k       = cnt_q >> 1;
	assign diff    = (DW+1)'(med_q) - (DW+1)'(centre_q);
	assign absd    = diff[DW] ? DW'(-diff) : DW'(diff);
	assign abs_sum = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

	assign status.scan_last = (j_q == cnt_q - CNT_W'(1));
	assign status.found     = (less_q <= k) && (k < leq_q);
	assign status.out_free  = !out_valid || out_ready;

	// window store, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.store && room) mem[cnt_q[AW-1:0]] <= in_sample;
		rd_q <= mem[rd_addr];
	end

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= cmof_pkg::THR_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	// count, sums and centre; cleared when the result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			sum_q    <= '0;
			sq_q     <= '0;
			centre_q <= '0;
		end else if (cmd.load_out) begin
			cnt_q    <= '0;
			sum_q    <= '0;
			sq_q     <= '0;
			centre_q <= '0;
		end else if (cmd.store && room) begin
			cnt_q <= cnt_q + CNT_W'(1);
			sum_q <= sum_q + SUM_W'(in_sample);
			sq_q  <= sq_q + SQ_W'(unsigned'(32'(in_sample) * 32'(in_sample)));
			if (in_center) centre_q <= in_sample;
		end
	end

	// rank counting walk over the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_v_q <= 1'b0;
			i_q      <= '0;
			j_q      <= '0;
		end else begin
			scan_v_q <= cmd.scan;
			if (cmd.store) i_q <= '0;
			else if (cmd.next_i) i_q <= i_q + CNT_W'(1);
			if (cmd.cap) j_q <= '0;
			else if (cmd.scan) j_q <= j_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			cand_q <= rd_q;
			less_q <= '0;
			leq_q  <= '0;
		end else if (scan_v_q) begin
			if (rd_q < cand_q) less_q <= less_q + CNT_W'(1);
			if (rd_q <= cand_q) leq_q <= leq_q + CNT_W'(1);
		end
		if (cmd.take_med) med_q <= cand_q;
	end

	// deviation test: (256*n*d)^2 > T^2 * (n*S2 - S^2)
	always_ff @(posedge clk) begin
		if (cmd.m1) begin
			ns2_q <= VW'(cnt_q) * VW'(sq_q);
			nd_q  <= ND_W'(cnt_q) * ND_W'(absd);
		end
		if (cmd.m2) begin
			ss_q <= VW'(abs_sum) * VW'(abs_sum);
			tt_q <= TT_W'(thr_q) * TT_W'(thr_q);
		end
		if (cmd.m3) begin
			v_q    <= ns2_q - ss_q;
			left_q <= (2*ND_W)'(nd_q) * (2*ND_W)'(nd_q);
		end
		if (cmd.m4) rlo_q <= (TT_W+VL)'(tt_q) * (TT_W+VL)'(v_q[VL-1:0]);
		if (cmd.m5) rhi_q <= (TT_W+VH)'(tt_q) * (TT_W+VH)'(v_q[VW-1:VL]);
		if (cmd.m6) right_q <= (RIGHT_W'(rhi_q) << VL) + RIGHT_W'(rlo_q);
		if (cmd.m7) rep_q <= (RIGHT_W'(left_q) << 16) > right_q;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_value    <= rep_q ? med_q : centre_q;
			out_replaced <= rep_q;
		end
	end

endmodule
`default_nettype wire
